// File: sv/spq_pkg.sv
// spq_pkg: shared types and constants of the sorted priority queue
// operation and status codes, controller states, command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 8;
    localparam int DATA_W   = VALUE_W + PRIO_W;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_DUMP = 2'd3
    } spq_func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2
    } spq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } spq_state_t;

    // what the output register loads
    typedef enum logic [1:0] {
        OSEL_CODE,
        OSEL_HEAD,
        OSEL_DUMP
    } spq_osel_t;

    typedef struct packed {
        logic        load_in;
        logic        enq;
        logic        deq;
        logic        rot;
        logic        dump_load;
        logic        out_load;
        spq_osel_t   out_sel;
        spq_status_t out_status;
    } spq_cmd_t;

    typedef struct packed {
        spq_func_t func;
        logic      full;
        logic      empty;
        logic      out_free;
        logic      rem_last;
    } spq_stat_t;

endpackage

`default_nettype wire

// File: sv/spq_datapath.sv
// spq_datapath: sorted shift-register cells, entry count, dump counter,
// input capture and output register
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [spq_pkg::DATA_W-1:0]   s_tdata,
    input  wire logic [spq_pkg::FUNC_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [spq_pkg::DATA_W-1:0]        m_tdata,
    output logic [spq_pkg::STATUS_W-1:0]      m_tuser,
    output logic                              m_tlast,
    input  wire spq_pkg::spq_cmd_t            cmd,
    output spq_pkg::spq_stat_t                stat
);

    localparam int PW = (PRIO_WIDTH < spq_pkg::PRIO_W) ? PRIO_WIDTH : spq_pkg::PRIO_W;
    localparam int CW = $clog2(DEPTH + 1);

    logic [spq_pkg::VALUE_W-1:0] val_reg [DEPTH];
    logic [spq_pkg::VALUE_W-1:0] val_next[DEPTH];
    logic [PW-1:0]               pri_reg [DEPTH];
    logic [PW-1:0]               pri_next[DEPTH];
    logic [DEPTH-1:0]            ge;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rem_reg, rem_next;

    logic [spq_pkg::VALUE_W-1:0] in_val_reg;
    logic [PW-1:0]               in_pri_reg;
    spq_pkg::spq_func_t          in_func_reg;

    logic                          m_valid_reg;
    logic [spq_pkg::VALUE_W-1:0]   m_val_reg;
    logic [spq_pkg::PRIO_W-1:0]    m_pri_reg;
    spq_pkg::spq_status_t          m_stat_reg;
    logic                          m_last_reg;

    // cells that stay ahead of a new entry
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CW'(i) < cnt_reg) && (pri_reg[i] >= in_pri_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (cmd.enq) begin
                if (!ge[i]) begin
                    if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
                        val_next[i] = in_val_reg;
                        pri_next[i] = in_pri_reg;
                    end else begin
                        val_next[i] = val_reg[(i == 0) ? 0 : i-1];
                        pri_next[i] = pri_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (cmd.deq) begin
                if (i < DEPTH-1) begin
                    val_next[i] = val_reg[(i < DEPTH-1) ? i+1 : i];
                    pri_next[i] = pri_reg[(i < DEPTH-1) ? i+1 : i];
                end
            end else if (cmd.rot) begin
                // head wraps around behind the last stored entry
                if (i == DEPTH-1 || CW'(i + 1) == cnt_reg) begin
                    val_next[i] = val_reg[0];
                    pri_next[i] = pri_reg[0];
                end else begin
                    val_next[i] = val_reg[(i < DEPTH-1) ? i+1 : i];
                    pri_next[i] = pri_reg[(i < DEPTH-1) ? i+1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.enq) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (cmd.deq) begin
            cnt_next = cnt_reg - CW'(1);
        end
        rem_next = rem_reg;
        if (cmd.dump_load) begin
            rem_next = cnt_reg;
        end else if (cmd.rot) begin
            rem_next = rem_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rem_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_val_reg  <= s_tdata[spq_pkg::VALUE_W-1:0];
            in_pri_reg  <= PW'(s_tdata[spq_pkg::DATA_W-1:spq_pkg::VALUE_W]);
            in_func_reg <= spq_pkg::spq_func_t'(s_tuser);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (cmd.out_sel)
                spq_pkg::OSEL_HEAD: begin
                    m_val_reg  <= val_reg[0];
                    m_pri_reg  <= spq_pkg::PRIO_W'(pri_reg[0]);
                    m_stat_reg <= spq_pkg::STAT_OK;
                    m_last_reg <= 1'b1;
                end
                spq_pkg::OSEL_DUMP: begin
                    m_val_reg  <= val_reg[0];
                    m_pri_reg  <= spq_pkg::PRIO_W'(pri_reg[0]);
                    m_stat_reg <= spq_pkg::STAT_OK;
                    m_last_reg <= (rem_reg == CW'(1));
                end
                default: begin
                    m_val_reg  <= '0;
                    m_pri_reg  <= '0;
                    m_stat_reg <= cmd.out_status;
                    m_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pri_reg, m_val_reg};
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

    assign stat.func     = in_func_reg;
    assign stat.full     = (cnt_reg == CW'(DEPTH));
    assign stat.empty    = (cnt_reg == '0);
    assign stat.out_free = !m_valid_reg || m_tready;
    assign stat.rem_last = (rem_reg == CW'(1));

endmodule

`default_nettype wire

// File: sv/spq_ctrl.sv
// spq_ctrl: controller state machine of the sorted priority queue
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t       cmd
);

    spq_pkg::spq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                if (stat.out_free) begin
                    if (stat.func == spq_pkg::FUNC_DUMP && !stat.empty) begin
                        state_next = spq_pkg::S_DUMP;
                    end else begin
                        state_next = spq_pkg::S_IDLE;
                    end
                end
            end
            spq_pkg::S_DUMP: begin
                if (stat.out_free && stat.rem_last) begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default: state_next = spq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.out_sel    = spq_pkg::OSEL_CODE;
        cmd.out_status = spq_pkg::STAT_OK;
        s_tready       = 1'b0;
        unique case (state_reg)
            spq_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            spq_pkg::S_EXEC: begin
                if (stat.out_free) begin
                    unique case (stat.func)
                        spq_pkg::FUNC_ENQ: begin
                            cmd.out_load   = 1'b1;
                            cmd.enq        = !stat.full;
                            cmd.out_status = stat.full ? spq_pkg::STAT_OVER
                                                       : spq_pkg::STAT_OK;
                        end
                        spq_pkg::FUNC_DEQ, spq_pkg::FUNC_PEEK: begin
                            cmd.out_load = 1'b1;
                            if (stat.empty) begin
                                cmd.out_status = spq_pkg::STAT_UNDER;
                            end else begin
                                cmd.out_sel = spq_pkg::OSEL_HEAD;
                                cmd.deq     = (stat.func == spq_pkg::FUNC_DEQ);
                            end
                        end
                        spq_pkg::FUNC_DUMP: begin
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = spq_pkg::STAT_UNDER;
                            end else begin
                                cmd.dump_load = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            spq_pkg::S_DUMP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = spq_pkg::OSEL_DUMP;
                    cmd.rot      = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue kept in descending priority order
// flow: an item is taken in idle, and for enqueue, dequeue and peek its result is loaded
// into the output register in the execute state once the output is free
// dump streams every stored entry, one entry per cycle while the output is free, from the rotating cell row
// one item at a time; the next item is taken once the controller is back in idle
// reset: aresetn low at a clock edge empties the queue and drops any pending result
// depends on spq_pkg, spq_ctrl, spq_datapath
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input channel
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [spq_pkg::DATA_W-1:0]   s_tdata,  // value[31:0], priority_req[39:32]
    input  wire logic [spq_pkg::FUNC_W-1:0]   s_tuser,  // func[1:0]
    // result channel
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [spq_pkg::DATA_W-1:0]        m_tdata,  // out_value[31:0], out_priority[39:32]
    output logic [spq_pkg::STATUS_W-1:0]      m_tuser,  // status[1:0]
    output logic                              m_tlast   // last
);

    // commands from the controller, status back from the datapath
    spq_pkg::spq_cmd_t  cmd;
    spq_pkg::spq_stat_t stat;

    // state machine: idle, execute one operation, stream a dump
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // sorted cell row with parallel priority compares, count and output register
    spq_datapath #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

// File: sv/spq_checker.sv
// spq_checker: port-level checks of the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [spq_pkg::DATA_W-1:0]   s_tdata,
    input wire logic [spq_pkg::FUNC_W-1:0]   s_tuser,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [spq_pkg::DATA_W-1:0]   m_tdata,
    input wire logic [spq_pkg::STATUS_W-1:0] m_tuser,
    input wire logic                         m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // error results carry no entry and close the item
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != spq_pkg::STAT_OK |-> m_tdata == '0 && m_tlast)
        else $error("error result with payload or without last");

    // no status code beyond overflow
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    // one item at a time: input is closed in the cycle after a transfer
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
